### rtl/core/spts_pkg.sv
// Package for the speed to pulse timer setting block.
// Holds the arithmetic constants, register indexes and the divider stage type.
// No dependencies.
package spts_pkg;

  localparam logic [63:0] BASE_TICKS   = 64'd18000000000;
  localparam logic [63:0] PERIOD_LIMIT = 64'd65535;
  localparam int          MAX_PRESCALE = 3;

  localparam int SPEED_W = 8;
  localparam int PPK_W   = 16;
  localparam int LAT_W   = 8;
  localparam int CMP_W   = 16;
  localparam int PRE_W   = 2;
  localparam int DIV_W   = PPK_W + SPEED_W;

  localparam int QUO_W      = 20;
  localparam int STEP_BITS  = 4;
  localparam int DIV_STAGES = QUO_W / STEP_BITS;

  // the product register loaded at the accept edge, the divider stages, the result register
  localparam int LATENCY = DIV_STAGES + 2;

  localparam logic [63:0] REM_INIT_W = BASE_TICKS >> QUO_W;
  localparam logic [DIV_W-1:0] REM_INIT = REM_INIT_W[DIV_W-1:0];

  // a divisor at or below this leaves a period too long even for 1:8
  localparam logic [63:0] FAULT_DIV_MAX_W =
    BASE_TICKS / (PERIOD_LIMIT << MAX_PRESCALE);
  localparam logic [DIV_W-1:0] FAULT_DIV_MAX = FAULT_DIV_MAX_W[DIV_W-1:0];

  localparam logic [QUO_W-1:0] LIMIT_Q = PERIOD_LIMIT[QUO_W-1:0];

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_KM  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LATENCY_ADJUST = 8'd1;

  localparam logic [PPK_W-1:0] PPK_RESET = 16'd8000;
  localparam logic [LAT_W-1:0] LAT_RESET = 8'd43;

  typedef struct packed {
    logic             valid;
    logic             off;
    logic [LAT_W-1:0] lat;
    logic [DIV_W-1:0] divisor;
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } stage_t;

endpackage

### rtl/core/spts_div_stage.sv
// One register stage of the restoring divider: STEP_BITS quotient bits.
// Depends on spts_pkg for widths and the stage type.
module spts_div_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  spts_pkg::stage_t               stage_in,
  input  logic [spts_pkg::STEP_BITS-1:0] num_bits,
  output spts_pkg::stage_t               stage_out
);

  spts_pkg::stage_t stage_next;

  always_comb begin
    logic [spts_pkg::DIV_W:0]   trial;
    logic [spts_pkg::DIV_W-1:0] r;
    logic [spts_pkg::QUO_W-1:0] q;
    r = stage_in.rem;
    q = stage_in.quo;
    trial = '0;
    for (int b = spts_pkg::STEP_BITS - 1; b >= 0; b--) begin
      trial = {r, num_bits[b]};
      q = {q[spts_pkg::QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, stage_in.divisor}) begin
        trial = trial - {1'b0, stage_in.divisor};
        q[0] = 1'b1;
      end
      r = trial[spts_pkg::DIV_W-1:0];
    end
    stage_next = stage_in;
    stage_next.rem = r;
    stage_next.quo = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out <= '0;
    end else begin
      stage_out <= stage_next;
    end
  end

endmodule

### rtl/core/speed_to_pulse_timer_setting.sv
// Top level: speed to pulse timer setting, product register, divider stages, result.
// The result is strobed on done after the product register, the divider stages and the result register.
// Throughput: one item per cycle; busy is low except during reset; the receiver cannot stall.
// The divider has five stages, four quotient bits per stage.
// Reset (rst, synchronous) drops items in flight and restores the register defaults.
module speed_to_pulse_timer_setting (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [spts_pkg::SPEED_W-1:0]    speed_kmh,
  output logic                            done,
  output logic                            output_enable,
  output logic [spts_pkg::PRE_W-1:0]      prescale_log2,
  output logic [spts_pkg::CMP_W-1:0]      compare_value,
  output logic [spts_pkg::LAT_W-1:0]      latency_reload,
  output logic                            fault,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spts_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [spts_pkg::PPK_W-1:0] pulses_per_km;
  logic [spts_pkg::LAT_W-1:0] latency_adjust;
  logic                       accept;

  spts_pkg::stage_t pipe [0:spts_pkg::DIV_STAGES];

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_km  <= spts_pkg::PPK_RESET;
      latency_adjust <= spts_pkg::LAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spts_pkg::CFG_PULSES_PER_KM:  pulses_per_km  <= cfg_data[spts_pkg::PPK_W-1:0];
        spts_pkg::CFG_LATENCY_ADJUST: latency_adjust <= cfg_data[spts_pkg::LAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pipe[0].valid   <= accept;
    pipe[0].off     <= (speed_kmh == '0);
    pipe[0].lat     <= latency_adjust;
    pipe[0].divisor <= {{spts_pkg::SPEED_W{1'b0}}, pulses_per_km}
                     * {{spts_pkg::PPK_W{1'b0}}, speed_kmh};
    pipe[0].rem     <= spts_pkg::REM_INIT;
    pipe[0].quo     <= '0;
  end

  for (genvar j = 0; j < spts_pkg::DIV_STAGES; j++) begin : g_div
    localparam logic [63:0] NUM_SHIFTED =
      spts_pkg::BASE_TICKS >> (spts_pkg::QUO_W - spts_pkg::STEP_BITS * (j + 1));
    spts_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .stage_in  (pipe[j]),
      .num_bits  (NUM_SHIFTED[spts_pkg::STEP_BITS-1:0]),
      .stage_out (pipe[j+1])
    );
  end

  spts_pkg::stage_t           last;
  logic                       fault_c;
  logic                       enable_c;
  logic [spts_pkg::PRE_W-1:0] shift_c;
  logic [spts_pkg::QUO_W-1:0] scaled_c;

  assign last     = pipe[spts_pkg::DIV_STAGES];
  assign fault_c  = !last.off && (last.divisor <= spts_pkg::FAULT_DIV_MAX);
  assign enable_c = !last.off && !fault_c;

  always_comb begin
    if (last.quo < spts_pkg::LIMIT_Q) begin
      shift_c = 2'd0;
    end else if ((last.quo >> 1) < spts_pkg::LIMIT_Q) begin
      shift_c = 2'd1;
    end else if ((last.quo >> 2) < spts_pkg::LIMIT_Q) begin
      shift_c = 2'd2;
    end else begin
      shift_c = 2'd3;
    end
  end

  assign scaled_c = last.quo >> shift_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    output_enable  <= enable_c;
    fault          <= fault_c;
    prescale_log2  <= enable_c ? shift_c : '0;
    compare_value  <= enable_c ? scaled_c[spts_pkg::CMP_W-1:0] : '0;
    latency_reload <= enable_c ? (last.lat >> shift_c) : '0;
  end

endmodule

### rtl/core/spts_checker.sv
// Port-level checker for speed_to_pulse_timer_setting, attached by bind.
// Depends on spts_pkg for widths and latency.
module spts_assertions (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic                            output_enable,
  input logic [spts_pkg::PRE_W-1:0]      prescale_log2,
  input logic [spts_pkg::CMP_W-1:0]      compare_value,
  input logic [spts_pkg::LAT_W-1:0]      latency_reload,
  input logic                            fault
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(spts_pkg::LATENCY) done)
    else $error("accepted item not strobed after fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, spts_pkg::LATENCY))
    else $error("result strobed without an accepted item");

  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !output_enable) |->
      (prescale_log2 == '0 && compare_value == '0 && latency_reload == '0))
    else $error("switched-off result carries nonzero settings");

  a_on_range: assert property (@(posedge clk) disable iff (rst)
    (done && output_enable) |->
      (!fault && compare_value != 16'hFFFF &&
       (prescale_log2 == '0 || compare_value >= 16'd32767)))
    else $error("running result with bad period or prescale");

endmodule

bind speed_to_pulse_timer_setting spts_assertions u_assertions (.*);
